// ===== rtl/plcr_pkg.sv =====
// shared types and constants for the piecewise-linear color ramp
package plcr_pkg;

  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int PROD_W   = VALUE_W + CHAN_W;
  localparam int STEP_W   = $clog2(CHAN_W);
  localparam int CH_W     = $clog2(NUM_CHAN);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // one table entry; rgb[0] red, rgb[1] green, rgb[2] blue
  typedef struct packed {
    logic signed [VALUE_W-1:0]          brk;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]    rgb;
  } plcr_entry_t;

  localparam int ENTRY_W = $bits(plcr_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOWER,
    ST_SCAN,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_LOAD
  } plcr_state_t;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_BLACK,
    RES_RAM
  } plcr_res_sel_t;

  typedef struct packed {
    logic          ram_we;
    logic          accept_lookup;
    logic          scan_step;
    logic          take_lo;
    logic          take_hi;
    plcr_res_sel_t res_sel;
    logic          mul;
    logic          sum;
    logic          div_step;
    logic          load_out;
  } plcr_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic above_value;
    logic scan_last;
    logic step_zero;
    logic last_ch;
    logic out_free;
  } plcr_status_t;

endpackage

// ===== rtl/plcr_if.sv =====
// request and response channel interfaces of the color ramp
interface plcr_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [6:0]         entry_index;
  logic signed [31:0] sample_value;
  logic [7:0]         entry_red;
  logic [7:0]         entry_green;
  logic [7:0]         entry_blue;

  modport source (
    output valid, opcode, entry_index, sample_value, entry_red, entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, sample_value, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

interface plcr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface

// ===== rtl/plcr_ram.sv =====
// generic single-write, single-read ram with registered read data
module plcr_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/plcr_ctrl.sv =====
// controller state machine for table writes, scan and interpolation
module plcr_ctrl
  import plcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_opcode,
  output logic         in_ready,
  input  plcr_status_t status,
  output plcr_cmd_t    cmd
);

  plcr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_opcode == OP_LOOKUP) begin
          state_next = status.count_zero ? ST_LOAD : ST_FIRST;
        end
      end
      ST_FIRST: state_next = ST_LOWER;
      ST_LOWER: begin
        state_next = (status.above_value || status.count_one) ? ST_LOAD : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.above_value) begin
          state_next = ST_MUL;
        end else if (status.scan_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = ST_DIV;
      ST_DIV: begin
        if (status.step_zero) begin
          state_next = status.last_ch ? ST_LOAD : ST_MUL;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_sel = RES_HOLD;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_opcode == OP_WRITE) begin
            cmd.ram_we = 1'b1;
          end else begin
            cmd.accept_lookup = 1'b1;
            if (status.count_zero) begin
              cmd.res_sel = RES_BLACK;
            end
          end
        end
      end
      ST_FIRST: cmd.scan_step = 1'b1;
      ST_LOWER: begin
        cmd.scan_step = 1'b1;
        if (status.above_value || status.count_one) begin
          cmd.res_sel = RES_RAM;
        end else begin
          cmd.take_lo = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.above_value) begin
          cmd.take_hi = 1'b1;
        end else if (status.scan_last) begin
          cmd.res_sel = RES_RAM;
        end else begin
          cmd.take_lo = 1'b1;
        end
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_SUM:  cmd.sum = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_LOAD: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/plcr_dp.sv =====
// datapath: entry count, table ram, scan registers, blend and serial divide
module plcr_dp
  import plcr_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_wdata,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic [CHAN_W-1:0]         entry_red,
  input  logic [CHAN_W-1:0]         entry_green,
  input  logic [CHAN_W-1:0]         entry_blue,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [CHAN_W-1:0]         red,
  output logic [CHAN_W-1:0]         green,
  output logic [CHAN_W-1:0]         blue,
  input  plcr_cmd_t                 cmd,
  output plcr_status_t              status
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_W-1:0]              entry_count;
  logic [CNT_W-1:0]                n_eff;
  logic [CNT_W-1:0]                n;
  logic [CNT_W-1:0]                k;
  logic signed [VALUE_W-1:0]       v;
  plcr_entry_t                     lo;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] hi_rgb;
  logic [VALUE_W-1:0]              num;
  logic [VALUE_W-1:0]              den;
  logic [VALUE_W-1:0]              dn;
  logic [PROD_W-1:0]               pa;
  logic [PROD_W-1:0]               pb;
  logic [PROD_W-1:0]               rem;
  logic [STEP_W-1:0]               step;
  logic [CHAN_W-1:0]               q;
  logic [CH_W-1:0]                 ch;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] res;

  plcr_entry_t                     wr_entry;
  plcr_entry_t                     rd_entry;
  logic [ENTRY_W-1:0]              rd_data;
  logic [31:0]                     idx_ext;
  logic                            wr_en;
  logic [VALUE_W:0]                num_w;
  logic [VALUE_W:0]                den_w;
  logic [VALUE_W:0]                dn_w;
  logic [PROD_W-1:0]               den_sh;
  logic                            ge;
  logic [CHAN_W-1:0]               q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // counts above the table depth act as the full table
  always_comb begin
    if (32'(entry_count) > TABLE_DEPTH) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(entry_count);
    end
  end

  // writes to slots beyond the table are dropped
  always_comb begin
    idx_ext         = 32'(entry_index);
    wr_en           = cmd.ram_we && (idx_ext < TABLE_DEPTH);
    wr_entry.brk    = sample_value;
    wr_entry.rgb[0] = entry_red;
    wr_entry.rgb[1] = entry_green;
    wr_entry.rgb[2] = entry_blue;
  end

  plcr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_ext[AW-1:0]),
    .wdata (wr_entry),
    .raddr (k[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_entry = plcr_entry_t'(rd_data);

  // operands of the blend, all known non-negative and below 2^32
  always_comb begin
    num_w = {v[VALUE_W-1], v} - {lo.brk[VALUE_W-1], lo.brk};
    den_w = {rd_entry.brk[VALUE_W-1], rd_entry.brk} - {lo.brk[VALUE_W-1], lo.brk};
    dn_w  = {rd_entry.brk[VALUE_W-1], rd_entry.brk} - {v[VALUE_W-1], v};
  end

  // restoring divide; quotient fits in one channel so only CHAN_W steps
  always_comb begin
    den_sh = PROD_W'(den) << step;
    ge     = rem >= den_sh;
    q_next = q | (CHAN_W'(ge) << step);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_lookup) begin
      v <= sample_value;
      n <= n_eff;
      k <= '0;
    end else if (cmd.scan_step) begin
      k <= k + CNT_W'(1);
    end
    if (cmd.take_lo) begin
      lo <= rd_entry;
    end
    if (cmd.take_hi) begin
      hi_rgb <= rd_entry.rgb;
      num    <= num_w[VALUE_W-1:0];
      den    <= den_w[VALUE_W-1:0];
      dn     <= dn_w[VALUE_W-1:0];
      ch     <= '0;
    end
    if (cmd.mul) begin
      pa <= PROD_W'(num) * PROD_W'(hi_rgb[ch]);
      pb <= PROD_W'(dn) * PROD_W'(lo.rgb[ch]);
    end
    if (cmd.sum) begin
      rem  <= pa + pb;
      step <= STEP_W'(CHAN_W - 1);
      q    <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - den_sh;
      end
      q    <= q_next;
      step <= step - STEP_W'(1);
      if (step == '0) begin
        res[ch] <= q_next;
        ch      <= ch + CH_W'(1);
      end
    end
    case (cmd.res_sel)
      RES_BLACK: res <= '0;
      RES_RAM:   res <= rd_entry.rgb;
      default:   ;
    endcase
    if (cmd.load_out) begin
      red   <= res[0];
      green <= res[1];
      blue  <= res[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.count_zero  = (n_eff == '0);
    status.count_one   = (n == CNT_W'(1));
    status.above_value = (rd_entry.brk > v);
    status.scan_last   = (k == n);
    status.step_zero   = (step == '0);
    status.last_ch     = (ch == CH_W'(NUM_CHAN - 1));
    status.out_free    = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  // a finished result never overwrites one that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending beat");

  // upper break lies strictly above the value, lower at or below
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.take_hi |=> (den > num) && (dn != '0))
    else $error("blend divisor not above numerator");

  // remainder stays below twice the shifted divisor at each divide step
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < (den_sh << 1))
    else $error("divide remainder out of range");

  // the table is only written while no lookup is in flight
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> !cmd.scan_step && !cmd.div_step && !cmd.mul)
    else $error("table write during a lookup");
`endif

endmodule

// ===== rtl/piecewise_linear_color_ramp_unit.sv =====
// top level of the piecewise-linear color ramp: table writes and rgb lookups
// a write beat gives no result; writes can follow every cycle
// a lookup on an empty table gives black without a scan; otherwise the table is scanned
// one entry at a time (one ram read port), then each channel runs the
// blend multiply, sum and 8-step serial divide; the next beat is taken once it is done
// rst is synchronous, active high: clears entry_count, the state and the result valid
module piecewise_linear_color_ramp_unit
  import plcr_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  plcr_req_if.sink           req,
  plcr_rsp_if.source         rsp,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  // command and status between the controller and the datapath
  plcr_cmd_t    cmd;
  plcr_status_t status;

  // controller: accepts beats only when no lookup is in flight; the result
  // register in the datapath lets it take the next beat while a result waits
  plcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: entry_count register, table ram, scan pointer, lower and upper
  // entries, blend products, serial divider and the output register
  plcr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .entry_index  (req.entry_index),
    .sample_value (req.sample_value),
    .entry_red    (req.entry_red),
    .entry_green  (req.entry_green),
    .entry_blue   (req.entry_blue),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .red          (rsp.red),
    .green        (rsp.green),
    .blue         (rsp.blue),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== dv/piecewise_linear_color_ramp_unit_tb.sv =====
`timescale 1ns / 100ps
// color ramp unit testbench: directed and random writes and lookups against a shadow ramp
module piecewise_linear_color_ramp_unit_tb
  import plcr_pkg::*;
();

  localparam int RAMP_DEPTH    = 128;
  // covers the longest lookup, so no beat is still in flight after it
  localparam int SETTLE_CYCLES = 200;
  localparam int BEAT_TARGET   = 1450;
  localparam int MAX_WAIT      = 18;
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;

  // channel 0 red, 1 green, 2 blue, same layout as the table entry
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  plcr_req_if req_ch ();
  plcr_rsp_if rsp_ch ();

  piecewise_linear_color_ramp_unit #(
    .TABLE_DEPTH(RAMP_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the color table and the entry count register
  plcr_entry_t        ramp_shadow [RAMP_DEPTH];
  logic [COUNT_W-1:0] count_shadow;
  // colors owed by the block, oldest lookup first
  rgb_t               expected_colors [$];

  int mismatch_count;
  int beats_taken;
  // when set, that side never idles (gives back-to-back stretches)
  bit send_calm;
  bit recv_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  // idle cycles before a beat: mostly none, sometimes short, sometimes long
  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, MAX_WAIT);
      1: return $urandom_range(0, 2);
      default: return 0;
    endcase
  endfunction

  function automatic longint rand63();
    return longint'({$urandom, $urandom} >> 1);
  endfunction

  function automatic rgb_t rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b);
    return {b, g, r};
  endfunction

  // channel values lean toward the extremes
  function automatic rgb_t random_rgb();
    rgb_t col;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      case ($urandom_range(0, 5))
        0: col[ch] = '0;
        1: col[ch] = '1;
        default: col[ch] = CHAN_W'($urandom_range(0, 255));
      endcase
    end
    return col;
  endfunction

  // ---------------------------------------------------------------------------
  // shadow ramp: color for one sample value, exact integer blend
  // ---------------------------------------------------------------------------
  function automatic rgb_t ramp_color(logic signed [VALUE_W-1:0] v);
    int          n;
    int          k;
    longint      off;
    longint      den;
    plcr_entry_t lo;
    plcr_entry_t hi;
    rgb_t        mix;
    // a count above the table depth acts as the full table
    n = (count_shadow > RAMP_DEPTH) ? RAMP_DEPTH : int'(count_shadow);
    if (n == 0) return '0;
    lo = ramp_shadow[0];
    if (v < $signed(lo.brk) || n == 1) return lo.rgb;
    // first break above the value wins, even if breaks are out of order;
    // the lower entry is then at or below the value so den stays positive
    for (k = 1; k < n; k++) begin
      hi = ramp_shadow[k];
      if ($signed(hi.brk) > v) begin
        off = longint'(v) - longint'($signed(lo.brk));
        den = longint'($signed(hi.brk)) - longint'($signed(lo.brk));
        for (int ch = 0; ch < NUM_CHAN; ch++)
          mix[ch] = CHAN_W'((off * longint'(hi.rgb[ch]) +
                             (den - off) * longint'(lo.rgb[ch])) / den);
        return mix;
      end
      lo = hi;
    end
    // at or beyond the last break
    return lo.rgb;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // drive one beat, wait for the handshake, then update the shadow or queue the color;
  // valid is left high so a following beat with no gap goes out back to back
  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val, input rgb_t col);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      if (req_ch.valid) req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.entry_index  <= idx;
    req_ch.sample_value <= val;
    req_ch.entry_red    <= col[0];
    req_ch.entry_green  <= col[1];
    req_ch.entry_blue   <= col[2];
    do @(posedge clk); while (!req_ch.ready);
    beats_taken++;
    if (op == OP_WRITE) begin
      ramp_shadow[idx].brk = val;
      ramp_shadow[idx].rgb = col;
    end else begin
      expected_colors.push_back(ramp_color(val));
    end
  endtask

  task automatic write_entry(input int idx, input logic signed [VALUE_W-1:0] brk,
                             input rgb_t col);
    send_beat(OP_WRITE, INDEX_W'(idx), brk, col);
  endtask

  // index and color fields are don't-care on a lookup, so they carry noise
  task automatic look_up(input logic signed [VALUE_W-1:0] v);
    send_beat(OP_LOOKUP, INDEX_W'($urandom_range(0, RAMP_DEPTH - 1)), v, random_rgb());
  endtask

  // stop sending and wait until every owed color has come back;
  // always passes a clock edge before returning so valid drops before the next beat
  task automatic drain_results();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_colors.size() != 0);
  endtask

  // the count register only changes while the block is idle
  task automatic set_entry_count(input logic [COUNT_W-1:0] n);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    count_shadow = n;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stalls and the checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // one stall draw per result beat
  initial begin : rsp_stall
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        if (rsp_ch.ready) rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // every accepted result beat is matched against the oldest owed color
  always @(posedge clk) begin : rsp_check
    rgb_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("result with no lookup pending",
                        {rsp_ch.blue, rsp_ch.green, rsp_ch.red}, 0);
      end else begin
        want = expected_colors.pop_front();
        if (rsp_ch.red !== want[0]) report_mismatch("red", rsp_ch.red, want[0]);
        if (rsp_ch.green !== want[1]) report_mismatch("green", rsp_ch.green, want[1]);
        if (rsp_ch.blue !== want[2]) report_mismatch("blue", rsp_ch.blue, want[2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building blocks
  // ---------------------------------------------------------------------------

  // fill slots 0..span-1; ordered ramps have strictly rising breaks with strides
  // from one lsb up to most of the remaining range, broken ones are pure noise
  task automatic build_ramp(input int span, input bit ordered);
    longint level;
    longint room;
    longint stride;
    case ($urandom_range(0, 3))
      0: level = VALUE_MIN;
      1: level = longint'($urandom_range(0, 32'h0004_0000)) - 64'sd131072;
      default: level = longint'($signed($urandom));
    endcase
    // keep room for at least one lsb per remaining entry
    if (level > VALUE_MAX - span) level = VALUE_MAX - span;
    for (int i = 0; i < span; i++) begin
      if (!ordered) begin
        level = longint'($signed($urandom));
      end else if (i > 0) begin
        room = (VALUE_MAX - level) / (span - i);
        case ($urandom_range(0, 3))
          0: stride = $urandom_range(1, 4);
          1: stride = $urandom_range(1, 32'h0002_0000);
          default: stride = 1 + rand63() % room;
        endcase
        if (stride > room) stride = room;
        level = level + stride;
      end
      write_entry(i, level[VALUE_W-1:0], random_rgb());
    end
  endtask

  // lookup value: mostly on, next to or between the breaks in use
  function automatic logic signed [VALUE_W-1:0] pick_probe(int span);
    int     k;
    longint v;
    longint gap;
    if (span == 0) return $urandom;
    k = $urandom_range(0, span - 1);
    v = longint'($signed(ramp_shadow[k].brk));
    case ($urandom_range(0, 7))
      0: v = longint'($signed($urandom));
      1: v = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
      2: v = v - 1;
      3: v = v + 1;
      4: ;
      default: begin
        if (k + 1 < span) begin
          gap = longint'($signed(ramp_shadow[k + 1].brk)) - v;
          if (gap > 0) v = v + rand63() % gap;
        end
      end
    endcase
    // values past the 32-bit range simply wrap
    return v[VALUE_W-1:0];
  endfunction

  // noise write: outside the slots in use when any are free, else anywhere
  task automatic stray_write(input int span);
    int idx;
    idx = (span < RAMP_DEPTH) ? $urandom_range(span, RAMP_DEPTH - 1)
                              : $urandom_range(0, RAMP_DEPTH - 1);
    write_entry(idx, $urandom, random_rgb());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // count of zero gives black whatever the value
  task automatic test_empty_table();
    set_entry_count(0);
    look_up(32'sh8000_0000);
    look_up(32'sh7fff_ffff);
  endtask

  // one entry in use: always the first color
  task automatic test_single_entry();
    write_entry(0, 32'sh0001_0000, rgb(8'hff, 8'h00, 8'h80));
    set_entry_count(1);
    look_up(32'sh8000_0000);
    look_up(32'sh0001_0000);
    look_up(32'sh7fff_ffff);
  endtask

  // below the first break, on each break, mid-segment, a one-lsb segment,
  // and at the last break, which sits at the top of the range
  task automatic test_ramp_edges();
    write_entry(0, 32'sh0001_0000, rgb(8'h0a, 8'hc8, 8'h00));
    write_entry(1, 32'sh0002_0000, rgb(8'hfa, 8'h00, 8'hff));
    write_entry(2, 32'sh0002_0001, rgb(8'h00, 8'hff, 8'h01));
    write_entry(3, 32'sh7fff_ffff, rgb(8'hff, 8'hff, 8'hff));
    set_entry_count(4);
    look_up(32'sh0000_ffff);
    look_up(32'sh0001_0000);
    look_up(32'sh0001_8000);
    look_up(32'sh0002_0000);
    look_up(32'sh0002_0001);
    look_up(32'sh7fff_fffe);
    look_up(32'sh7fff_ffff);
  endtask

  // one segment across the whole signed range: widest divisor and products
  task automatic test_full_span();
    write_entry(0, 32'sh8000_0000, rgb(8'h00, 8'hff, 8'h00));
    write_entry(1, 32'sh7fff_ffff, rgb(8'hff, 8'h00, 8'hff));
    set_entry_count(2);
    look_up(32'shffff_ffff);
    look_up(32'sh7fff_fffe);
  endtask

  // breaks out of order: the first break above the value still picks the segment
  task automatic test_unordered_breaks();
    write_entry(0, 32'sh0000_0000, rgb(8'h00, 8'h00, 8'h00));
    write_entry(1, 32'sh0003_0000, rgb(8'hff, 8'h80, 8'h40));
    write_entry(2, 32'sh0001_0000, rgb(8'h10, 8'h20, 8'h30));
    write_entry(3, 32'sh0002_0000, rgb(8'hff, 8'hff, 8'hff));
    set_entry_count(4);
    look_up(32'sh0001_8000);
    look_up(32'sh0002_8000);
    look_up(32'sh0003_0000);
  endtask

  // full table, then counts at and past the depth up to the register maximum
  task automatic test_count_beyond_depth();
    logic [COUNT_W-1:0] counts [3];
    counts = '{8'd128, 8'd129, 8'd255};
    build_ramp(RAMP_DEPTH, 1'b1);
    foreach (counts[c]) begin
      set_entry_count(counts[c]);
      repeat (6) look_up(pick_probe(RAMP_DEPTH));
    end
  endtask

  // phases of a fresh ramp, a new count and a run of lookups with some noise
  task automatic test_random_ramps();
    int used;
    int span;
    int looks;
    bit ordered;
    while (beats_taken < BEAT_TARGET) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      // mostly short ramps since lookup time grows with the count
      case ($urandom_range(0, 15))
        0: used = 0;
        1: used = 1;
        2: used = RAMP_DEPTH;
        3: used = $urandom_range(RAMP_DEPTH + 1, 255);
        4, 5: used = $urandom_range(11, RAMP_DEPTH - 1);
        default: used = $urandom_range(2, 10);
      endcase
      span    = (used > RAMP_DEPTH) ? RAMP_DEPTH : used;
      ordered = ($urandom_range(0, 5) != 0);
      build_ramp(span, ordered);
      set_entry_count(COUNT_W'(used));
      looks = $urandom_range(8, 40);
      for (int i = 0; i < looks; i++) begin
        if ($urandom_range(0, 9) == 0) stray_write(span);
        else look_up(pick_probe(span));
        // hold off now and then until the block has caught up
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_WRITE;
    req_ch.entry_index  <= '0;
    req_ch.sample_value <= '0;
    req_ch.entry_red    <= '0;
    req_ch.entry_green  <= '0;
    req_ch.entry_blue   <= '0;
    count_shadow   = '0;
    mismatch_count = 0;
    beats_taken    = 0;
    send_calm      = 1'b0;
    recv_calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_single_entry();
    test_ramp_edges();
    test_full_span();
    test_unordered_breaks();
    test_count_beyond_depth();
    test_random_ramps();

    // everything owed has arrived; give stray results time to show up
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
